>>> rtl/two_channel_lux_calculation_top_defines.svh
// Assertion macros shared by the two-channel lux calculation RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef TWO_CHANNEL_LUX_CALCULATION_TOP_DEFINES_SVH
`define TWO_CHANNEL_LUX_CALCULATION_TOP_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define TLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define TLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

>>> rtl/tlc_pkg.sv
// Shared types, constants and slope tables for the two-channel lux calculation.
// Depends on nothing; used by tlc_div and two_channel_lux_calculation_top.
package tlc_pkg;

    localparam int COUNT_W   = 16;
    localparam int SCALE_W   = 19;
    localparam int CH_W      = 25;
    localparam int REM_W     = 26;
    localparam int Q_W       = 11;
    localparam int SLOPE_W   = 10;
    localparam int PROD_W    = 35;
    localparam int LUX_W     = 21;
    localparam int FRAC_CH   = 10;
    localparam int FRAC_LUX  = 14;
    localparam int NUM_BANDS = 7;

    localparam logic [SCALE_W-1:0] SCALE_SHORT   = 19'h07517;
    localparam logic [SCALE_W-1:0] SCALE_MEDIUM  = 19'h00FE7;
    localparam logic [SCALE_W-1:0] SCALE_NOMINAL = 19'h00400;

    localparam logic [1:0] INTEG_SHORT  = 2'd0;
    localparam logic [1:0] INTEG_MEDIUM = 2'd1;
    localparam logic [1:0] INTEG_NOMINAL = 2'd2;

    typedef enum logic [1:0] {
        REG_INTEGRATION = 2'd0,
        REG_HIGH_GAIN   = 2'd1,
        REG_PACKAGE     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SLOPE_W-1:0] limit;
        logic [SLOPE_W-1:0] b;
        logic [SLOPE_W-1:0] m;
    } band_t;

    typedef struct packed {
        logic [SLOPE_W-1:0] b;
        logic [SLOPE_W-1:0] m;
    } slopes_t;

    // One item as it travels through the ratio divider.
    typedef struct packed {
        logic [COUNT_W-1:0] bb;
        logic [CH_W-1:0]    ch0;
        logic [CH_W-1:0]    ch1;
        logic               zero;
        logic               big;
    } item_t;

    localparam band_t STD_TABLE [NUM_BANDS] = '{
        '{10'h040, 10'h1f2, 10'h1be},
        '{10'h080, 10'h214, 10'h2d1},
        '{10'h0c0, 10'h23f, 10'h37b},
        '{10'h100, 10'h270, 10'h3fe},
        '{10'h138, 10'h16f, 10'h1fc},
        '{10'h19a, 10'h0d2, 10'h0fb},
        '{10'h29a, 10'h018, 10'h012}
    };

    localparam band_t CS_TABLE [NUM_BANDS] = '{
        '{10'h043, 10'h204, 10'h1ad},
        '{10'h085, 10'h228, 10'h2c1},
        '{10'h0c8, 10'h253, 10'h363},
        '{10'h10a, 10'h282, 10'h3df},
        '{10'h14d, 10'h177, 10'h1dd},
        '{10'h19a, 10'h101, 10'h127},
        '{10'h029a, 10'h037, 10'h02b}
    };

    // The rounded ratio (q + 1) >> 1 is at most a band limit exactly when
    // the raw quotient q is at most twice that limit.
    function automatic slopes_t pick_slopes(input logic [Q_W-1:0] q,
                                            input logic package_sel);
        slopes_t s;
        band_t   t;
        s = '0;
        for (int i = NUM_BANDS - 1; i >= 0; i--) begin
            t = package_sel ? STD_TABLE[i] : CS_TABLE[i];
            if (q <= {t.limit, 1'b0}) begin
                s.b = t.b;
                s.m = t.m;
            end
        end
        return s;
    endfunction

endpackage

>>> rtl/tlc_div.sv
// Pipelined restoring divider giving the 11-bit quotient (ch1 << 10) / ch0.
// Depends on tlc_pkg; one quotient bit is resolved per register stage.
module tlc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  tlc_pkg::item_t             in_item,
    output logic                       out_valid,
    output tlc_pkg::item_t             out_item,
    output logic [tlc_pkg::Q_W-1:0]    out_q
);

    logic                          valid_reg [tlc_pkg::Q_W];
    tlc_pkg::item_t                item_reg  [tlc_pkg::Q_W];
    logic [tlc_pkg::REM_W-1:0]     rem_reg   [tlc_pkg::Q_W];
    logic [tlc_pkg::Q_W-1:0]       q_reg     [tlc_pkg::Q_W];

    for (genvar k = 0; k < tlc_pkg::Q_W; k++) begin : g_step
        logic                      valid_in;
        tlc_pkg::item_t            item_in;
        logic [tlc_pkg::REM_W-1:0] rem_in;
        logic [tlc_pkg::Q_W-1:0]   q_in;
        logic [tlc_pkg::REM_W-1:0] divisor;
        logic                      ge;
        logic [tlc_pkg::REM_W-1:0] diff;
        logic [tlc_pkg::REM_W-1:0] rem_next;
        logic [tlc_pkg::Q_W-1:0]   q_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign item_in  = in_item;
            assign rem_in   = {1'b0, in_item.ch1};
            assign q_in     = '0;
        end else begin : g_rest
            assign valid_in = valid_reg[k-1];
            assign item_in  = item_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign q_in     = q_reg[k-1];
        end

        // The partial remainder stays below twice the divisor, so one
        // compare and subtract settles each bit.
        assign divisor  = {1'b0, item_in.ch0};
        assign ge       = (rem_in >= divisor);
        assign diff     = ge ? (rem_in - divisor) : rem_in;
        assign rem_next = {diff[tlc_pkg::REM_W-2:0], 1'b0};
        assign q_next   = {q_in[tlc_pkg::Q_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[k] <= item_in;
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
            end
        end
    end

    assign out_valid = valid_reg[tlc_pkg::Q_W-1];
    assign out_item  = item_reg[tlc_pkg::Q_W-1];
    assign out_q     = q_reg[tlc_pkg::Q_W-1];

endmodule

>>> rtl/two_channel_lux_calculation_top.sv
// Two-channel lux calculation: one transaction of broadband and infrared
// counts in, one lux value out, every clock cycle while the output is not
// stalled. The pipeline has three stages for input capture, count scaling and
// divider setup, eleven stages of the ratio divider (one quotient bit each),
// then slope lookup, the two slope multiplies, the difference and the rounding
// stage. All stages advance together whenever the output register is empty or
// being read, so a stalled output holds the whole pipeline. Registers are
// written through the cfg channel, which is always ready, and must only change
// while no transaction is in flight.
// Depends on tlc_pkg, tlc_div and two_channel_lux_calculation_top_defines.svh.
`include "two_channel_lux_calculation_top_defines.svh"

module two_channel_lux_calculation_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [1:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlc_pkg::COUNT_W-1:0]   s_broadband_count,
    input  logic [tlc_pkg::COUNT_W-1:0]   s_infrared_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlc_pkg::LUX_W-1:0]     m_lux_value,
    output logic [tlc_pkg::COUNT_W-1:0]   m_broadband_echo
);

    logic [1:0] integration_select_reg;
    logic       high_gain_reg;
    logic       package_select_reg;
    logic       pipe_en;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integration_select_reg <= tlc_pkg::INTEG_NOMINAL;
            high_gain_reg          <= 1'b1;
            package_select_reg     <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                tlc_pkg::REG_INTEGRATION: integration_select_reg <= cfg_data;
                tlc_pkg::REG_HIGH_GAIN:   high_gain_reg          <= cfg_data[0];
                tlc_pkg::REG_PACKAGE:     package_select_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic m_valid_reg;
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // Stage 1: capture the counts and the scale factor.
    logic [tlc_pkg::SCALE_W-1:0] scale_base;
    logic [tlc_pkg::SCALE_W-1:0] scale_next;
    logic                        s1_valid_reg;
    logic [tlc_pkg::COUNT_W-1:0] s1_bb_reg;
    logic [tlc_pkg::COUNT_W-1:0] s1_ir_reg;
    logic [tlc_pkg::SCALE_W-1:0] s1_scale_reg;

    always_comb begin
        case (integration_select_reg)
            tlc_pkg::INTEG_SHORT:  scale_base = tlc_pkg::SCALE_SHORT;
            tlc_pkg::INTEG_MEDIUM: scale_base = tlc_pkg::SCALE_MEDIUM;
            default:               scale_base = tlc_pkg::SCALE_NOMINAL;
        endcase
        scale_next = high_gain_reg ? scale_base
                                   : {scale_base[tlc_pkg::SCALE_W-5:0], 4'b0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_bb_reg    <= s_broadband_count;
            s1_ir_reg    <= s_infrared_count;
            s1_scale_reg <= scale_next;
        end
    end

    // Stage 2: scaled channel counts.
    logic [tlc_pkg::PROD_W-1:0]  prod0;
    logic [tlc_pkg::PROD_W-1:0]  prod1;
    logic                        s2_valid_reg;
    logic [tlc_pkg::COUNT_W-1:0] s2_bb_reg;
    logic [tlc_pkg::CH_W-1:0]    s2_ch0_reg;
    logic [tlc_pkg::CH_W-1:0]    s2_ch1_reg;

    assign prod0 = tlc_pkg::PROD_W'(s1_bb_reg) * tlc_pkg::PROD_W'(s1_scale_reg);
    assign prod1 = tlc_pkg::PROD_W'(s1_ir_reg) * tlc_pkg::PROD_W'(s1_scale_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_bb_reg  <= s1_bb_reg;
            s2_ch0_reg <= prod0[tlc_pkg::PROD_W-1:tlc_pkg::FRAC_CH];
            s2_ch1_reg <= prod1[tlc_pkg::PROD_W-1:tlc_pkg::FRAC_CH];
        end
    end

    // Stage 3: divider setup. A quotient of 2048 or more lies far above the
    // last band, so it is only flagged and the divider never has to hold it.
    tlc_pkg::item_t s3_item_next;
    tlc_pkg::item_t s3_item_reg;
    logic           s3_valid_reg;

    always_comb begin
        s3_item_next.bb   = s2_bb_reg;
        s3_item_next.ch0  = s2_ch0_reg;
        s3_item_next.ch1  = s2_ch1_reg;
        s3_item_next.zero = (s2_ch0_reg == '0);
        s3_item_next.big  = (s2_ch0_reg != '0)
                         && ({1'b0, s2_ch1_reg} >= {s2_ch0_reg, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_item_reg <= s3_item_next;
        end
    end

    // Ratio divider.
    logic                     div_valid;
    tlc_pkg::item_t           div_item;
    logic [tlc_pkg::Q_W-1:0]  div_q;

    tlc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s3_valid_reg),
        .in_item   (s3_item_reg),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_q     (div_q)
    );

    // Slope lookup.
    logic [tlc_pkg::Q_W-1:0]     q_eff;
    tlc_pkg::slopes_t            slopes;
    logic                        band_valid_reg;
    logic [tlc_pkg::COUNT_W-1:0] band_bb_reg;
    logic [tlc_pkg::CH_W-1:0]    band_ch0_reg;
    logic [tlc_pkg::CH_W-1:0]    band_ch1_reg;
    logic [tlc_pkg::SLOPE_W-1:0] band_b_reg;
    logic [tlc_pkg::SLOPE_W-1:0] band_m_reg;

    always_comb begin
        q_eff  = div_item.zero ? '0 : div_q;
        slopes = div_item.big ? '0 : tlc_pkg::pick_slopes(q_eff, package_select_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            band_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            band_bb_reg  <= div_item.bb;
            band_ch0_reg <= div_item.ch0;
            band_ch1_reg <= div_item.ch1;
            band_b_reg   <= slopes.b;
            band_m_reg   <= slopes.m;
        end
    end

    // Slope products.
    logic                        mul_valid_reg;
    logic [tlc_pkg::COUNT_W-1:0] mul_bb_reg;
    logic [tlc_pkg::PROD_W-1:0]  pos_reg;
    logic [tlc_pkg::PROD_W-1:0]  neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            mul_valid_reg <= band_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mul_bb_reg <= band_bb_reg;
            pos_reg    <= tlc_pkg::PROD_W'(band_ch0_reg) * tlc_pkg::PROD_W'(band_b_reg);
            neg_reg    <= tlc_pkg::PROD_W'(band_ch1_reg) * tlc_pkg::PROD_W'(band_m_reg);
        end
    end

    // Difference, clamped at zero.
    logic                        diff_valid_reg;
    logic [tlc_pkg::COUNT_W-1:0] diff_bb_reg;
    logic [tlc_pkg::PROD_W-1:0]  diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            diff_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            diff_bb_reg <= mul_bb_reg;
            diff_reg    <= (pos_reg > neg_reg) ? (pos_reg - neg_reg) : '0;
        end
    end

    // Rounding, scaling and saturation into the output register.
    logic [tlc_pkg::PROD_W:0]              rounded;
    logic [tlc_pkg::PROD_W-tlc_pkg::FRAC_LUX:0] shifted;
    logic [tlc_pkg::LUX_W-1:0]             lux_next;
    logic [tlc_pkg::LUX_W-1:0]             lux_reg;
    logic [tlc_pkg::COUNT_W-1:0]           echo_reg;

    always_comb begin
        rounded  = {1'b0, diff_reg} + ((tlc_pkg::PROD_W + 1)'(1) << (tlc_pkg::FRAC_LUX - 1));
        shifted  = rounded[tlc_pkg::PROD_W:tlc_pkg::FRAC_LUX];
        lux_next = (shifted[tlc_pkg::PROD_W-tlc_pkg::FRAC_LUX:tlc_pkg::LUX_W] != '0)
                 ? '1 : shifted[tlc_pkg::LUX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= diff_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            lux_reg  <= lux_next;
            echo_reg <= diff_bb_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_lux_value      = lux_reg;
    assign m_broadband_echo = echo_reg;

    `TLC_ASSERT(a_stall_blocks_input, m_valid && !m_ready |-> !s_ready, "input accepted while output stalled")
    `TLC_ASSERT(a_big_ratio_zero_slopes, pipe_en && div_valid && div_item.big |=> band_b_reg == '0 && band_m_reg == '0, "ratio above last band did not give zero slopes")
    `TLC_ASSERT(a_stall_holds_diff, !pipe_en && diff_valid_reg |=> diff_valid_reg && $stable(diff_reg), "pipeline moved during a stall")
    `TLC_ASSERT_ALWAYS(a_reset_empties_output, !aresetn |=> !m_valid, "output valid after reset")

endmodule
